// File: hdl/indexed_min_heap_queue_top_assert.svh
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top_assert
// Assertion macros for the indexed min-heap queue.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_TOP_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_TOP_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define IMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a cause is followed by an effect in the next cycle.
`define IMHQ_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

// File: hdl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types, constants and helpers of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int NUM_IDS = 256;
  localparam int ID_W    = 8;
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 9;

  // Operation codes; the last one does nothing.
  localparam logic [1:0] F_INS = 2'd0;
  localparam logic [1:0] F_POP = 2'd1;
  localparam logic [1:0] F_UPD = 2'd2;
  localparam logic [1:0] F_NOP = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_PRESENT = 3'd3;
  localparam logic [2:0] ST_ABSENT  = 3'd4;

  // One heap slot: identifier and its key.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } slot_t;

  // True when key a is strictly greater than key b, both signed.
  function automatic logic key_gt(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    key_gt = $signed(a) > $signed(b);
  endfunction

endpackage

// File: hdl/indexed_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Indexed binary min-heap: insert, pop minimum and key update, with a
// position table from identifier to heap slot.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in_      in_valid / in_stall  in_func, in_elem_id, in_new_key
// out_     out_valid / out_stall out_id, out_key, out_status, out_occupancy
//
// One item at a time. A sift-up reads the parent and then compares at each
// level, and a sift-down reads both children and then compares (one slot RAM
// read port), up to 8 levels. Reset is synchronous and clears the count and
// all present bits at once. A stalled result holds in the output register;
// the next item is taken once the sequencer is back to idle.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_func,
  input  logic [imhq_pkg::ID_W-1:0] in_elem_id,
  input  logic signed [imhq_pkg::KEY_W-1:0] in_new_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [imhq_pkg::ID_W-1:0] out_id,
  output logic signed [imhq_pkg::KEY_W-1:0] out_key,
  output logic [2:0]                out_status,
  output logic [imhq_pkg::CNT_W-1:0] out_occupancy
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_POP_RD   = 4'd1;
  localparam logic [3:0] S_POP_LAST = 4'd2;
  localparam logic [3:0] S_UPD_POS  = 4'd3;
  localparam logic [3:0] S_SU_RD    = 4'd4;
  localparam logic [3:0] S_SU_CMP   = 4'd5;
  localparam logic [3:0] S_SD_L     = 4'd6;
  localparam logic [3:0] S_SD_R     = 4'd7;
  localparam logic [3:0] S_SD_CMP   = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]                  state_r, state_nxt;
  logic [imhq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [imhq_pkg::NUM_IDS-1:0] present_r, present_nxt;
  logic                        upd_r, upd_nxt;
  logic                        has_r_r, has_r_nxt;
  logic [imhq_pkg::ID_W-1:0]   idx_r, idx_nxt;
  imhq_pkg::slot_t             item_r, item_nxt;
  imhq_pkg::slot_t             left_r, left_nxt;
  logic [imhq_pkg::ID_W-1:0]   res_id_r, res_id_nxt;
  logic [imhq_pkg::KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [2:0]                  res_st_r, res_st_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [imhq_pkg::ID_W-1:0]   out_id_r;
  logic [imhq_pkg::KEY_W-1:0]  out_key_r;
  logic [2:0]                  out_st_r;
  logic [imhq_pkg::CNT_W-1:0]  out_occ_r;
  logic                        out_load;

  // RAM ports.
  logic                        slot_we, pos_we;
  logic [imhq_pkg::ID_W-1:0]   slot_waddr, slot_raddr, pos_waddr, pos_raddr;
  imhq_pkg::slot_t             slot_wdata, slot_rdata;
  logic [imhq_pkg::ID_W-1:0]   pos_wdata, pos_rdata;

  // Child and parent positions.
  logic [imhq_pkg::ID_W-1:0]   par_idx;
  logic [imhq_pkg::CNT_W-1:0]  lc_idx;
  logic [imhq_pkg::CNT_W:0]    rc_idx;
  imhq_pkg::slot_t             best;
  logic [imhq_pkg::ID_W-1:0]   best_idx;
  logic                        moved;

  logic in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign par_idx  = (idx_r - 8'd1) >> 1;
  assign lc_idx   = {idx_r, 1'b1};
  assign rc_idx   = {1'b0, lc_idx} + 10'd1;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Slot memory: identifier and key of each heap slot.
  imhq_ram #(.WIDTH($bits(imhq_pkg::slot_t)), .DEPTH(imhq_pkg::NUM_IDS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Position memory: slot of each identifier.
  imhq_ram #(.WIDTH(imhq_pkg::ID_W), .DEPTH(imhq_pkg::NUM_IDS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // Smallest of the moving item and its children during a sift-down.
  always_comb begin
    best     = item_r;
    best_idx = idx_r;
    moved    = 1'b0;
    if (imhq_pkg::key_gt(item_r.key, left_r.key)) begin
      best     = left_r;
      best_idx = lc_idx[imhq_pkg::ID_W-1:0];
      moved    = 1'b1;
    end
    if (has_r_r && imhq_pkg::key_gt(best.key, slot_rdata.key)) begin
      best     = slot_rdata;
      best_idx = rc_idx[imhq_pkg::ID_W-1:0];
      moved    = 1'b1;
    end
  end

  // Sequencer: decode, then walk the heap with a hole, one level at a time.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    present_nxt = present_r;
    upd_nxt     = upd_r;
    has_r_nxt   = has_r_r;
    idx_nxt     = idx_r;
    item_nxt    = item_r;
    left_nxt    = left_r;
    res_id_nxt  = res_id_r;
    res_key_nxt = res_key_r;
    res_st_nxt  = res_st_r;
    slot_we     = 1'b0;
    slot_waddr  = idx_r;
    slot_wdata  = item_r;
    slot_raddr  = '0;
    pos_we      = 1'b0;
    pos_waddr   = item_r.id;
    pos_wdata   = idx_r;
    pos_raddr   = in_elem_id;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_id_nxt  = '0;
          res_key_nxt = '0;
          res_st_nxt  = imhq_pkg::ST_OK;
          upd_nxt     = 1'b0;
          item_nxt    = '{id: in_elem_id, key: in_new_key};
          state_nxt   = S_DONE;
          unique case (in_func)
            imhq_pkg::F_INS: begin
              if (cnt_r == imhq_pkg::CNT_W'(imhq_pkg::NUM_IDS)) begin
                res_st_nxt = imhq_pkg::ST_FULL;
              end else if (present_r[in_elem_id]) begin
                res_st_nxt = imhq_pkg::ST_PRESENT;
              end else begin
                idx_nxt                 = cnt_r[imhq_pkg::ID_W-1:0];
                cnt_nxt                 = cnt_r + 9'd1;
                present_nxt[in_elem_id] = 1'b1;
                state_nxt               = S_SU_RD;
              end
            end
            imhq_pkg::F_POP: begin
              if (cnt_r == '0) begin
                res_st_nxt = imhq_pkg::ST_EMPTY;
              end else begin
                slot_raddr = '0;
                state_nxt  = S_POP_RD;
              end
            end
            imhq_pkg::F_UPD: begin
              if (!present_r[in_elem_id]) begin
                res_st_nxt = imhq_pkg::ST_ABSENT;
              end else begin
                pos_raddr = in_elem_id;
                state_nxt = S_UPD_POS;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_POP_RD: begin
        res_id_nxt                  = slot_rdata.id;
        res_key_nxt                 = slot_rdata.key;
        present_nxt[slot_rdata.id]  = 1'b0;
        cnt_nxt                     = cnt_r - 9'd1;
        slot_raddr                  = cnt_nxt[imhq_pkg::ID_W-1:0];
        state_nxt                   = (cnt_r == 9'd1) ? S_DONE : S_POP_LAST;
      end
      S_POP_LAST: begin
        item_nxt  = slot_rdata;
        idx_nxt   = '0;
        state_nxt = S_SD_L;
      end
      S_UPD_POS: begin
        idx_nxt = pos_rdata;
        if (pos_rdata == '0) begin
          state_nxt = S_SD_L;
        end else begin
          upd_nxt   = 1'b1;
          state_nxt = S_SU_RD;
        end
      end
      S_SU_RD: begin
        slot_raddr = par_idx;
        state_nxt  = (idx_r == '0) ? S_FIN : S_SU_CMP;
      end
      S_SU_CMP: begin
        if (imhq_pkg::key_gt(slot_rdata.key, item_r.key)) begin
          // Parent moves down into the hole.
          slot_we    = 1'b1;
          slot_wdata = slot_rdata;
          pos_we     = 1'b1;
          pos_waddr  = slot_rdata.id;
          idx_nxt    = par_idx;
          upd_nxt    = 1'b0;
          state_nxt  = S_SU_RD;
        end else if (upd_r) begin
          upd_nxt   = 1'b0;
          state_nxt = S_SD_L;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SD_L: begin
        slot_raddr = lc_idx[imhq_pkg::ID_W-1:0];
        state_nxt  = (lc_idx >= cnt_r) ? S_FIN : S_SD_R;
      end
      S_SD_R: begin
        left_nxt   = slot_rdata;
        has_r_nxt  = rc_idx < {1'b0, cnt_r};
        slot_raddr = rc_idx[imhq_pkg::ID_W-1:0];
        state_nxt  = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (moved) begin
          // Smaller child moves up into the hole.
          slot_we    = 1'b1;
          slot_wdata = best;
          pos_we     = 1'b1;
          pos_waddr  = best.id;
          idx_nxt    = best_idx;
          state_nxt  = S_SD_L;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        slot_we   = 1'b1;
        pos_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      present_r   <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      present_r   <= present_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    has_r_r   <= has_r_nxt;
    idx_r     <= idx_nxt;
    item_r    <= item_nxt;
    left_r    <= left_nxt;
    res_id_r  <= res_id_nxt;
    res_key_r <= res_key_nxt;
    res_st_r  <= res_st_nxt;
    if (out_load) begin
      out_id_r  <= res_id_r;
      out_key_r <= res_key_r;
      out_st_r  <= res_st_r;
      out_occ_r <= cnt_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_id        = out_id_r;
  assign out_key       = out_key_r;
  assign out_status    = out_st_r;
  assign out_occupancy = out_occ_r;

  // Assertions.
  `include "indexed_min_heap_queue_top_assert.svh"

  `IMHQ_ASSERT(a_cnt_max, cnt_r <= imhq_pkg::CNT_W'(imhq_pkg::NUM_IDS), "heap count over range")
  `IMHQ_ASSERT(a_sd_in_heap, (state_r != S_SD_CMP) || ({1'b0, idx_r} < cnt_r), "sift out of heap")
  `IMHQ_ASSERT_NEXT(a_busy, in_acc, state_r != S_IDLE, "item accepted without leaving idle")
  `IMHQ_ASSERT_NEXT(a_pop_cnt, state_r == S_POP_RD, cnt_r == $past(cnt_r) - 9'd1, "pop count")

endmodule

// File: hdl/imhq_ram.sv
// ----------------------------------------------------------------------------
// imhq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sim/indexed_min_heap_queue_top_tb.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top_tb
// Self-checking bench for the indexed min-heap queue. A heap model in the
// bench predicts every result item; a scoreboard compares them in order.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected result of one operation.
  typedef struct {
    logic [imhq_pkg::ID_W-1:0]  id;
    logic [imhq_pkg::KEY_W-1:0] key;
    logic [2:0]                 status;
    logic [imhq_pkg::CNT_W-1:0] occ;
  } heap_result_t;

  // Holds the predicted results and compares them with the block's output.
  class heap_scoreboard;
    heap_result_t pending[$];
    int errors;
    int checked;

    function void note_input(heap_result_t r);
      pending.insert(pending.size(), r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 50)
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task check_result(logic [imhq_pkg::ID_W-1:0] id, logic [imhq_pkg::KEY_W-1:0] key,
                      logic [2:0] status, logic [imhq_pkg::CNT_W-1:0] occ);
      heap_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result item with nothing pending", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (id !== e.id) report_mismatch("out_id", longint'(id), longint'(e.id));
      if (key !== e.key) report_mismatch("out_key", longint'(key), longint'(e.key));
      if (status !== e.status)
        report_mismatch("out_status", longint'(status), longint'(e.status));
      if (occ !== e.occ) report_mismatch("out_occupancy", longint'(occ), longint'(e.occ));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [imhq_pkg::ID_W-1:0] in_elem_id = '0;
  logic signed [imhq_pkg::KEY_W-1:0] in_new_key = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [imhq_pkg::ID_W-1:0] out_id;
  logic signed [imhq_pkg::KEY_W-1:0] out_key;
  logic [2:0] out_status;
  logic [imhq_pkg::CNT_W-1:0] out_occupancy;

  indexed_min_heap_queue_top i_dut (.*);

  always #4 clk = ~clk;

  // Heap model state.
  logic [imhq_pkg::ID_W-1:0]  mdl_slot [imhq_pkg::NUM_IDS];
  logic [imhq_pkg::CNT_W-1:0] mdl_pos [imhq_pkg::NUM_IDS];
  logic                       mdl_present [imhq_pkg::NUM_IDS];
  logic [imhq_pkg::KEY_W-1:0] mdl_key [imhq_pkg::NUM_IDS];
  int                         mdl_count;

  heap_scoreboard sb = new();
  int hold_long = 0;
  int ins_count = 0, pop_count = 0, upd_count = 0, err_count = 0;

  function automatic bit greater(logic [imhq_pkg::ID_W-1:0] a, logic [imhq_pkg::ID_W-1:0] b);
    return $signed(mdl_key[a]) > $signed(mdl_key[b]);
  endfunction

  function automatic void swap_at(int i, int j);
    logic [imhq_pkg::ID_W-1:0] t;
    t = mdl_slot[i];
    mdl_slot[i] = mdl_slot[j];
    mdl_slot[j] = t;
    mdl_pos[mdl_slot[i]] = imhq_pkg::CNT_W'(i);
    mdl_pos[mdl_slot[j]] = imhq_pkg::CNT_W'(j);
  endfunction

  function automatic void rise(int i);
    int p;
    while (i > 0 && i < mdl_count) begin
      p = (i - 1) / 2;
      if (!greater(mdl_slot[p], mdl_slot[i])) break;
      swap_at(p, i);
      i = p;
    end
  endfunction

  function automatic void sink(int i);
    int l, r, m;
    while (i < mdl_count) begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l >= mdl_count) break;
      if (greater(mdl_slot[i], mdl_slot[l])) m = l;
      if (r < mdl_count && greater(mdl_slot[m], mdl_slot[r])) m = r;
      if (m == i) break;
      swap_at(i, m);
      i = m;
    end
  endfunction

  // Applies one operation to the model and returns the result it expects.
  function automatic heap_result_t predict_heap_op(logic [1:0] f,
                                                   logic [imhq_pkg::ID_W-1:0] id,
                                                   logic [imhq_pkg::KEY_W-1:0] key);
    heap_result_t r;
    int i;
    logic [imhq_pkg::ID_W-1:0] top;
    r.id = '0;
    r.key = '0;
    r.status = imhq_pkg::ST_OK;
    if (f == imhq_pkg::F_INS) begin
      if (mdl_count >= imhq_pkg::NUM_IDS) r.status = imhq_pkg::ST_FULL;
      else if (mdl_present[id]) r.status = imhq_pkg::ST_PRESENT;
      else begin
        mdl_key[id] = key;
        mdl_slot[mdl_count] = id;
        mdl_pos[id] = imhq_pkg::CNT_W'(mdl_count);
        mdl_present[id] = 1;
        mdl_count++;
        rise(mdl_count - 1);
      end
    end else if (f == imhq_pkg::F_POP) begin
      if (mdl_count == 0) r.status = imhq_pkg::ST_EMPTY;
      else begin
        top = mdl_slot[0];
        r.id = top;
        r.key = mdl_key[top];
        mdl_count--;
        mdl_present[top] = 0;
        if (mdl_count > 0) begin
          mdl_slot[0] = mdl_slot[mdl_count];
          mdl_pos[mdl_slot[0]] = '0;
          sink(0);
        end
      end
    end else if (f == imhq_pkg::F_UPD) begin
      if (!mdl_present[id]) r.status = imhq_pkg::ST_ABSENT;
      else begin
        i = int'(mdl_pos[id]);
        mdl_key[id] = key;
        if (i > 0 && greater(mdl_slot[(i - 1) / 2], mdl_slot[i])) rise(i);
        else sink(i);
      end
    end
    r.occ = imhq_pkg::CNT_W'(mdl_count);
    return r;
  endfunction

  // Sends one item, after a random gap unless no_gap is set, and notes its expected result.
  task send_item(logic [1:0] f, logic [imhq_pkg::ID_W-1:0] id,
                 logic [imhq_pkg::KEY_W-1:0] key, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_elem_id <= id;
    in_new_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(predict_heap_op(f, id, key));
    case (f)
      imhq_pkg::F_INS: ins_count++;
      imhq_pkg::F_POP: pop_count++;
      imhq_pkg::F_UPD: upd_count++;
      default: err_count++;
    endcase
    @(negedge clk);
  endtask

  task send_random_gap(logic [1:0] f, logic [imhq_pkg::ID_W-1:0] id,
                       logic [imhq_pkg::KEY_W-1:0] key);
    send_item(f, id, key, $urandom_range(0, 3) == 0);
  endtask

  function automatic logic [imhq_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Receiver: a random wait before each result item, and one long hold-off
  // on request.
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (400) @(negedge clk);
        hold_long = 0;
        out_stall <= 0;
      end else begin
        wait_cycles = $urandom_range(0, 6);
        if (wait_cycles > 0) begin
          out_stall <= 1;
          repeat (wait_cycles) @(negedge clk);
          out_stall <= 0;
        end
        // Stay ready until the next result item is taken.
        do @(posedge clk); while (!(out_valid && !out_stall));
      end
    end
  end

  // Result monitor.
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_id, out_key, out_status, out_occupancy);

  // Run time limit.
  initial begin
    #3ms;
    $display("indexed_min_heap_queue_top test failed");
    $finish;
  end

  initial begin
    int n, f;
    mdl_count = 0;
    for (int k = 0; k < imhq_pkg::NUM_IDS; k++) mdl_present[k] = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: empty pop, absent update, idle code, extreme keys, duplicate insert, ties, last pop.
    send_item(imhq_pkg::F_POP, 8'd0, '0, 1'b0);
    send_item(imhq_pkg::F_UPD, 8'd5, '0, 1'b0);
    send_item(imhq_pkg::F_NOP, 8'hff, 32'hffff_ffff, 1'b0);
    send_item(imhq_pkg::F_INS, 8'd0, 32'h7fff_ffff, 1'b0);
    send_item(imhq_pkg::F_INS, 8'hff, 32'h8000_0000, 1'b0);
    send_item(imhq_pkg::F_INS, 8'hff, 32'd1, 1'b0);
    send_item(imhq_pkg::F_INS, 8'd1, 32'h8000_0000, 1'b0);
    send_item(imhq_pkg::F_INS, 8'd2, 32'd0, 1'b0);
    send_item(imhq_pkg::F_UPD, 8'd0, 32'h8000_0000, 1'b0);
    send_item(imhq_pkg::F_UPD, 8'd1, 32'h7fff_ffff, 1'b0);
    for (int k = 0; k < 6; k++) send_item(imhq_pkg::F_POP, 8'd0, '0, 1'b0);

    // Fill the heap completely, then try one more insert.
    for (int k = 0; k < imhq_pkg::NUM_IDS; k++)
      send_item(imhq_pkg::F_INS, imhq_pkg::ID_W'(k), rand_key(), 1'b1);
    send_item(imhq_pkg::F_INS, 8'd7, 32'd3, 1'b0);
    for (int k = 0; k < 20; k++)
      send_item(imhq_pkg::F_UPD, imhq_pkg::ID_W'($urandom_range(0, 255)), rand_key(), 1'b0);

    // Long receiver hold-off while items keep coming.
    hold_long = 1;
    for (int k = 0; k < 30; k++) send_item(imhq_pkg::F_POP, 8'd0, '0, 1'b1);
    wait_drained();
    while (mdl_count > 0) send_item(imhq_pkg::F_POP, 8'd0, '0, 1'b1);

    // Random mix around a moderate occupancy.
    n = 0;
    while (n < 150) begin
      f = $urandom_range(0, 19);
      if (f < 8) send_random_gap(imhq_pkg::F_INS, imhq_pkg::ID_W'($urandom), rand_key());
      else if (f < 14) send_random_gap(imhq_pkg::F_POP, imhq_pkg::ID_W'($urandom), $urandom);
      else if (f < 19) begin
        if (mdl_count > 0 && $urandom_range(0, 4) != 0)
          send_random_gap(imhq_pkg::F_UPD, mdl_slot[$urandom_range(0, mdl_count - 1)],
                          rand_key());
        else send_random_gap(imhq_pkg::F_UPD, imhq_pkg::ID_W'($urandom), rand_key());
      end else send_random_gap(imhq_pkg::F_NOP, imhq_pkg::ID_W'($urandom), $urandom);
      n++;
      if (n == 75) wait_drained();
    end

    wait_drained();
    repeat (60) @(negedge clk);
    $display("Covered %0d inserts, %0d pops, %0d updates, %0d idle codes; %0d results checked.",
             ins_count, pop_count, upd_count, err_count, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("indexed_min_heap_queue_top test passed");
    else
      $display("indexed_min_heap_queue_top test failed");
    $finish;
  end
endmodule
